FILE: hdl/fdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned COUNT_W = 17;

    localparam logic [BYTE_W-1:0]  HEADER_RESET = 8'hfe;
    localparam logic [CRC_W-1:0]   POLY_RESET   = 16'ha001;
    localparam logic [CRC_W-1:0]   INIT_RESET   = 16'hffff;

    // fixed frame layout positions
    localparam logic [COUNT_W-1:0] IDX_CRC_LO   = 17'd2;
    localparam logic [COUNT_W-1:0] IDX_CRC_HI   = 17'd3;
    localparam logic [COUNT_W-1:0] IDX_LEN_LO   = 17'd6;
    localparam logic [COUNT_W-1:0] CNT_LEN_FROM = 17'd6;
    localparam logic [COUNT_W-1:0] FRAME_OVHD   = 17'd9;

    // register map, byte address = 4 * index
    localparam int unsigned        ADDR_W       = 4;
    localparam logic [1:0]         REG_HEADER   = 2'd0;
    localparam logic [1:0]         REG_POLY     = 2'd1;
    localparam logic [1:0]         REG_INIT     = 2'd2;

    typedef enum logic [2:0] {
        ST_HUNT1  = 3'd0,
        ST_HUNT2  = 3'd1,
        ST_CRCVER = 3'd2,
        ST_LEN    = 3'd3,
        ST_BODY   = 3'd4
    } t_stage;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] byte_index;
        logic               frame_last;
        logic               frame_abort;
        logic               crc_ok;
        logic [COUNT_W-1:0] frame_length;
    } t_result;

    // reflected crc, one byte per call, eight shift steps
    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fdc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module fdc_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [fdc_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic [fdc_pkg::BYTE_W-1:0]  i_header_byte,
    input  wire logic [fdc_pkg::CRC_W-1:0]   i_crc_poly,
    input  wire logic [fdc_pkg::CRC_W-1:0]   i_crc_init,
    output fdc_pkg::t_result                 o_result,
    output logic                             o_has_result
);
    import fdc_pkg::*;

    t_stage             r_stage, n_stage;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_expected, n_expected;
    logic [BYTE_W-1:0]  r_len_lo, n_len_lo;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [CRC_W-1:0]   r_rx_crc, n_rx_crc;

    logic               hdr_match;
    logic [COUNT_W-1:0] count_inc;
    logic [CRC_W-1:0]   crc_next;
    logic               body_done;

    assign hdr_match = (i_byte == i_header_byte);
    assign count_inc = r_count + 1'b1;
    assign crc_next  = crc_feed(r_crc, i_byte, i_crc_poly);
    assign body_done = (count_inc >= r_expected);

    always_comb begin
        n_stage = r_stage;
        case (r_stage)
            ST_HUNT2: begin
                n_stage = hdr_match ? ST_CRCVER : ST_HUNT1;
            end
            ST_CRCVER: begin
                if (count_inc >= CNT_LEN_FROM) begin
                    n_stage = ST_LEN;
                end
            end
            ST_LEN: begin
                if (r_count != IDX_LEN_LO) begin
                    n_stage = ST_BODY;
                end
            end
            ST_BODY: begin
                if (body_done) begin
                    n_stage = ST_HUNT1;
                end
            end
            default: begin
                n_stage = hdr_match ? ST_HUNT2 : ST_HUNT1;
            end
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_expected   = r_expected;
        n_len_lo     = r_len_lo;
        n_crc        = r_crc;
        n_rx_crc     = r_rx_crc;
        o_has_result = 1'b1;
        o_result     = '0;
        o_result.out_byte   = i_byte;
        o_result.byte_index = r_count;
        case (r_stage)
            ST_HUNT2: begin
                if (hdr_match) begin
                    n_count  = COUNT_W'(2);
                    n_crc    = i_crc_init;
                    n_rx_crc = '0;
                end else begin
                    o_result.byte_index  = COUNT_W'(1);
                    o_result.frame_abort = 1'b1;
                    n_count    = '0;
                    n_expected = '0;
                end
            end
            ST_CRCVER: begin
                if (r_count == IDX_CRC_LO) begin
                    n_rx_crc[7:0] = i_byte;
                end else if (r_count == IDX_CRC_HI) begin
                    n_rx_crc[15:8] = i_byte;
                end else begin
                    n_crc = crc_next;
                end
                n_count = count_inc;
            end
            ST_LEN: begin
                n_crc = crc_next;
                if (r_count == IDX_LEN_LO) begin
                    n_len_lo = i_byte;
                end else begin
                    n_expected = FRAME_OVHD + {1'b0, i_byte, r_len_lo};
                end
                n_count = count_inc;
            end
            ST_BODY: begin
                n_crc   = crc_next;
                n_count = count_inc;
                if (body_done) begin
                    o_result.frame_last   = 1'b1;
                    o_result.crc_ok       = (crc_next == r_rx_crc);
                    o_result.frame_length = r_expected;
                    n_count    = '0;
                    n_expected = '0;
                end
            end
            default: begin
                // hunting, also covers unused codes
                o_result.byte_index = '0;
                n_expected          = '0;
                if (hdr_match) begin
                    n_count = COUNT_W'(1);
                end else begin
                    n_count      = '0;
                    o_has_result = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= ST_HUNT1;
            r_count    <= '0;
            r_expected <= '0;
            r_len_lo   <= '0;
            r_crc      <= '0;
            r_rx_crc   <= '0;
        end else if (i_accept) begin
            r_stage    <= n_stage;
            r_count    <= n_count;
            r_expected <= n_expected;
            r_len_lo   <= n_len_lo;
            r_crc      <= n_crc;
            r_rx_crc   <= n_rx_crc;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/frame_deframer_crc16_check.sv
`timescale 1ns / 1ps
`default_nettype none

// length-prefixed frame deframer with crc-16 check
// input channel: one link byte per item on i_in_byte, i_valid / o_stall
// output channel: one item per frame byte, o_valid / i_stall, with the byte,
//   its index in the frame, frame_last, frame_abort, and on the footer byte
//   crc_ok and frame_length; bytes outside a frame produce no item
// frame: two header bytes, crc (le), version, length L (le), L body bytes,
//   footer; crc runs from the version field through the footer
// an accepted byte's item is registered in the output or the skid register
// throughput: one byte per cycle while o_stall is low; the crc for a byte
//   is done in one step in front of the result register
// when the receiver stalls, the output register holds and one more item
//   lands in the skid register; o_stall rises only while the skid is full
// reset (synchronous, active low) returns to hunting the first header byte,
//   empties both output registers and loads register defaults
//   (header 0xfe, poly 0xa001, init 0xffff)
// config: apb registers header_byte @0x0, crc_poly @0x4, crc_init @0x8

module frame_deframer_crc16_check (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [fdc_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [fdc_pkg::BYTE_W-1:0]         o_out_byte,
    output logic [fdc_pkg::COUNT_W-1:0]        o_byte_index,
    output logic                               o_frame_last,
    output logic                               o_frame_abort,
    output logic                               o_crc_ok,
    output logic [fdc_pkg::COUNT_W-1:0]        o_frame_length,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fdc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import fdc_pkg::*;

    logic [BYTE_W-1:0] r_header_byte;
    logic [CRC_W-1:0]  r_crc_poly;
    logic [CRC_W-1:0]  r_crc_init;
    logic              cfg_wr;
    logic [1:0]        cfg_sel;

    t_result           new_res;
    logic              new_has;
    logic              in_acc;
    logic              out_fire;

    t_result           r_out, r_skid;
    logic              r_out_valid, r_skid_valid;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= HEADER_RESET;
            r_crc_poly    <= POLY_RESET;
            r_crc_init    <= INIT_RESET;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_HEADER: r_header_byte <= pwdata[BYTE_W-1:0];
                REG_POLY:   r_crc_poly    <= pwdata[CRC_W-1:0];
                REG_INIT:   r_crc_init    <= pwdata[CRC_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_HEADER: prdata = {24'h0, r_header_byte};
            REG_POLY:   prdata = {16'h0, r_crc_poly};
            REG_INIT:   prdata = {16'h0, r_crc_init};
            default:    prdata = '0;
        endcase
    end

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    fdc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_byte        (i_in_byte),
        .i_header_byte (r_header_byte),
        .i_crc_poly    (r_crc_poly),
        .i_crc_init    (r_crc_init),
        .o_result      (new_res),
        .o_has_result  (new_has)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && new_has) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_acc && new_has) begin
            if (!r_out_valid || out_fire) begin
                r_out <= new_res;
            end else begin
                r_skid <= new_res;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_last   = r_out.frame_last;
    assign o_frame_abort  = r_out.frame_abort;
    assign o_crc_ok       = r_out.crc_ok;
    assign o_frame_length = r_out.frame_length;

    // skid only fills behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full with empty output register");

    a_last_abort_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_frame_last && o_frame_abort))
        else $error("frame_last and frame_abort together");

    a_last_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> (o_frame_length >= FRAME_OVHD
            && o_byte_index + 1'b1 == o_frame_length))
        else $error("footer index does not match frame length");

    a_crc_ok_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_last) |-> (!o_crc_ok && o_frame_length == '0))
        else $error("crc status outside footer item");

endmodule

`default_nettype wire
